@@ rtl/core/bmpdec_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpdec_pkg
// shared types and constants for the streaming bmp pixel decoder
// ----------------------------------------------------------------------------
package bmpdec_pkg;

   localparam int unsigned HeaderBytes = 54;
   localparam logic [15:0] BmpMagic    = 16'h4D42;
   // largest accepted width or height, row and column state is 13 bits
   localparam int unsigned MaxDim      = 4096;

   typedef enum logic [1:0] {
      KIND_PIXEL   = 2'd0,
      KIND_BAD_SIG = 2'd1,
      KIND_BAD_BPP = 2'd2,
      KIND_TOO_BIG = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      MODE_NONE = 3'd0,
      MODE_1BPP = 3'd1,
      MODE_4BPP = 3'd2,
      MODE_8BPP = 3'd3,
      MODE_24BPP = 3'd4,
      MODE_32BPP = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] pix_x;
      logic [11:0] pix_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        last;
   } rsp_type;

   // work handed from the parser to the pixel emitter
   typedef struct packed {
      logic        is_status;
      kind_type    kind;
      logic [3:0]  count;    // pixels in this byte
      logic [7:0]  idx_byte; // index bits, msb first
      mode_type    mode;
      logic [12:0] col;
      logic [12:0] row;
      logic [23:0] rgb;
      logic [7:0]  alpha;
   } job_type;

endpackage

@@ rtl/core/bmpdec_emit.sv @@
// ----------------------------------------------------------------------------
// bmpdec_emit
// palette memory and pixel emitter, one result per cycle unless rsp_stall holds the output
// ----------------------------------------------------------------------------
module bmpdec_emit #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pal_we,
   input  logic [7:0]          pal_addr,
   input  logic [23:0]         pal_data,
   input  logic                job_valid,
   output logic                job_ready,
   input  bmpdec_pkg::job_type job,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bmpdec_pkg::rsp_type rsp_data
);
   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   logic [23:0] pal_mem [PALETTE_DEPTH];

   // stage a: job being expanded
   logic                job_ff, job_in;
   bmpdec_pkg::job_type cur_ff, cur_in;
   logic [3:0]          k_ff, k_in;
   // stage b: palette read in flight
   logic                b_vld_ff;
   bmpdec_pkg::rsp_type b_ff, b_in;
   logic                b_pal_ff, b_pal_in, b_blk_ff, b_blk_in;
   logic [23:0]         rd_ff;
   // output register
   logic                o_vld_ff;
   bmpdec_pkg::rsp_type o_ff;

   logic o_free, b_adv, a_adv;
   logic [7:0] idx;
   logic [AW-1:0] raddr;

   assign o_free = !o_vld_ff || !rsp_stall;
   assign b_adv  = !b_vld_ff || o_free;
   assign a_adv  = job_ff && b_adv;
   assign job_ready = !job_ff || (a_adv && (cur_ff.is_status ||
                      k_ff + 4'd1 >= cur_ff.count));

   always_comb begin
      unique case (cur_ff.mode)
         bmpdec_pkg::MODE_1BPP: idx = {7'd0, cur_ff.idx_byte[3'd7 - k_ff[2:0]]};
         bmpdec_pkg::MODE_4BPP: idx = (k_ff == 4'd0) ? {4'd0, cur_ff.idx_byte[7:4]}
                                                    : {4'd0, cur_ff.idx_byte[3:0]};
         default:               idx = cur_ff.idx_byte;
      endcase
      raddr = idx[AW-1:0];
      b_pal_in = (cur_ff.mode == bmpdec_pkg::MODE_1BPP) ||
                 (cur_ff.mode == bmpdec_pkg::MODE_4BPP) ||
                 (cur_ff.mode == bmpdec_pkg::MODE_8BPP);
      b_blk_in = ({24'd0, idx} >= 32'(PALETTE_DEPTH));
      b_in = '0;
      b_in.kind = cur_ff.kind;
      b_in.last = cur_ff.is_status || (k_ff + 4'd1 >= cur_ff.count);
      if (!cur_ff.is_status) begin
         b_in.pix_x = 12'(cur_ff.col + 13'(k_ff));
         b_in.pix_y = cur_ff.row[11:0];
         b_in.red   = cur_ff.rgb[23:16];
         b_in.green = cur_ff.rgb[15:8];
         b_in.blue  = cur_ff.rgb[7:0];
         b_in.alpha = cur_ff.alpha;
      end
      job_in = job_ff; cur_in = cur_ff; k_in = k_ff;
      if (a_adv) k_in = k_ff + 4'd1;
      if (job_ready) begin
         job_in = job_valid; cur_in = job; k_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_we && ({24'd0, pal_addr} < 32'(PALETTE_DEPTH)))
         pal_mem[pal_addr[AW-1:0]] <= pal_data;
      if (a_adv) rd_ff <= pal_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff <= 1'b0; b_vld_ff <= 1'b0; o_vld_ff <= 1'b0; k_ff <= '0;
      end else begin
         job_ff <= job_in; k_ff <= k_in;
         if (b_adv) b_vld_ff <= a_adv;
         if (o_free) o_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (a_adv) begin
         b_ff <= b_in; b_pal_ff <= b_pal_in && !cur_ff.is_status;
         b_blk_ff <= b_blk_in;
      end
      if (o_free && b_vld_ff) begin
         o_ff <= b_ff;
         if (b_pal_ff) begin
            o_ff.red   <= b_blk_ff ? 8'd0 : rd_ff[23:16];
            o_ff.green <= b_blk_ff ? 8'd0 : rd_ff[15:8];
            o_ff.blue  <= b_blk_ff ? 8'd0 : rd_ff[7:0];
         end
      end
   end

   assign rsp_valid = o_vld_ff;
   assign rsp_data  = o_ff;
endmodule

@@ rtl/core/bmp_stream_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// bmp_stream_pixel_decoder
// streaming uncompressed bmp decoder, one file byte in, pixels out
// ----------------------------------------------------------------------------
// channel | dir | payload  | meaning
// req     | in  | req_type | one file byte, first restarts the file
// rsp     | out | rsp_type | one pixel or one header status
//
// a byte is parsed in the cycle it is accepted; header, palette and row
// state are updated at once and the palette goes to a memory with one
// write and one read port; the emitter expands a byte into its results,
// up to 8 at 1 bpp, and reads the palette a register ahead of the output
// reset is synchronous and leaves the block waiting for a first byte
// rsp_stall holds the output register, and req_stall rises while the
// emitter still has results of an earlier byte to expand
module bmp_stream_pixel_decoder #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bmpdec_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bmpdec_pkg::rsp_type rsp_data
);
   logic [10:0] off_ff, off_in;
   logic [31:0] sh_ff, sh_in;
   logic [15:0] sig_ff, sig_in;
   logic [31:0] w_ff, w_in, h_ff, h_in;
   bmpdec_pkg::mode_type mode_ff, mode_in;
   logic [12:0] col_ff, col_in, row_ff, row_in;
   logic [14:0] rbc_ff, rbc_in, stride_ff, stride_in;
   logic [1:0]  ph_ff, ph_in;
   logic [23:0] stg_ff, stg_in;
   logic        halt_ff, halt_in;

   logic job_valid, job_ready, acc, pal_we;
   logic [7:0] pal_addr;
   bmpdec_pkg::job_type job;

   assign req_stall = !job_ready;
   assign acc = req_valid && job_ready;

   always_comb begin
      logic [7:0]  b;
      logic [10:0] pend, p;
      logic [5:0]  bpp;
      logic [17:0] bits;
      logic [14:0] bytes;
      logic [12:0] left, n;
      logic [1:0]  endp;
      b = req_data.data_byte;
      off_in = off_ff; sh_in = sh_ff; sig_in = sig_ff; w_in = w_ff; h_in = h_ff;
      mode_in = mode_ff; col_in = col_ff; row_in = row_ff; rbc_in = rbc_ff;
      stride_in = stride_ff; ph_in = ph_ff; stg_in = stg_ff; halt_in = halt_ff;
      job_valid = 1'b0; job = '0; job.mode = mode_ff; pal_we = 1'b0;
      pal_addr = '0; bpp = '0; bits = '0; bytes = '0; left = '0; n = '0;
      endp = '0; p = '0;
      unique case (mode_ff)
         bmpdec_pkg::MODE_1BPP: pend = 11'd62;
         bmpdec_pkg::MODE_4BPP: pend = 11'd118;
         bmpdec_pkg::MODE_8BPP: pend = 11'd1078;
         default:               pend = 11'(bmpdec_pkg::HeaderBytes);
      endcase
      if (acc) begin
         if (req_data.first) begin
            off_in = '0; sh_in = '0; sig_in = '0; w_in = '0; h_in = '0;
            mode_in = bmpdec_pkg::MODE_NONE; col_in = '0; row_in = '0;
            rbc_in = '0; stride_in = '0; ph_in = '0; stg_in = '0;
            halt_in = 1'b0;
            pend = 11'(bmpdec_pkg::HeaderBytes);
         end
         if (!halt_in) begin
            if (off_in < 11'(bmpdec_pkg::HeaderBytes)) begin
               sh_in = {b, sh_in[31:8]};
               off_in = off_in + 11'd1;
               if (off_in == 11'd2) sig_in = sh_in[31:16];
               else if (off_in == 11'd22) w_in = sh_in;
               else if (off_in == 11'd26) h_in = sh_in;
               else if (off_in == 11'd30) begin
                  unique case (sh_in[31:16])
                     16'd1:   mode_in = bmpdec_pkg::MODE_1BPP;
                     16'd4:   mode_in = bmpdec_pkg::MODE_4BPP;
                     16'd8:   mode_in = bmpdec_pkg::MODE_8BPP;
                     16'd24:  mode_in = bmpdec_pkg::MODE_24BPP;
                     16'd32:  mode_in = bmpdec_pkg::MODE_32BPP;
                     default: mode_in = bmpdec_pkg::MODE_NONE;
                  endcase
               end else if (off_in == 11'(bmpdec_pkg::HeaderBytes)) begin
                  job.is_status = 1'b1;
                  if (sig_in != bmpdec_pkg::BmpMagic) begin
                     job_valid = 1'b1; job.kind = bmpdec_pkg::KIND_BAD_SIG;
                     halt_in = 1'b1;
                  end else if (mode_in == bmpdec_pkg::MODE_NONE) begin
                     job_valid = 1'b1; job.kind = bmpdec_pkg::KIND_BAD_BPP;
                     halt_in = 1'b1;
                  end else if (w_in > 32'(bmpdec_pkg::MaxDim) ||
                               h_in > 32'(bmpdec_pkg::MaxDim)) begin
                     job_valid = 1'b1; job.kind = bmpdec_pkg::KIND_TOO_BIG;
                     halt_in = 1'b1;
                  end else if (w_in == 32'd0 || h_in == 32'd0) begin
                     halt_in = 1'b1;
                  end else begin
                     unique case (mode_in)
                        bmpdec_pkg::MODE_1BPP:  bpp = 6'd1;
                        bmpdec_pkg::MODE_4BPP:  bpp = 6'd4;
                        bmpdec_pkg::MODE_8BPP:  bpp = 6'd8;
                        bmpdec_pkg::MODE_24BPP: bpp = 6'd24;
                        default:                bpp = 6'd32;
                     endcase
                     // width fits 13 bits here, times 32 at most
                     bits = 18'(w_in[12:0]) * 18'(bpp) + 18'd7;
                     bytes = 15'(bits >> 3);
                     stride_in = (bytes + 15'd3) & ~15'd3;
                     row_in = 13'(h_in - 32'd1);
                  end
               end
            end else if (off_in < pend) begin
               p = off_in - 11'(bmpdec_pkg::HeaderBytes);
               off_in = off_in + 11'd1;
               unique case (p[1:0])
                  2'd0: stg_in = {16'd0, b};
                  2'd1: stg_in[15:8] = b;
                  2'd2: begin
                     pal_we = 1'b1; pal_addr = p[9:2];
                     stg_in = '0;
                  end
                  default: ;
               endcase
            end else begin
               job.col = col_in; job.row = row_in; job.idx_byte = b;
               job.alpha = 8'hFF;
               left = (13'(w_in) > col_in) ? 13'(w_in) - col_in : 13'd0;
               unique case (mode_in)
                  bmpdec_pkg::MODE_1BPP: n = (left > 13'd8) ? 13'd8 : left;
                  bmpdec_pkg::MODE_4BPP: n = (left > 13'd2) ? 13'd2 : left;
                  bmpdec_pkg::MODE_8BPP: n = (left > 13'd1) ? 13'd1 : left;
                  default: begin
                     endp = (mode_in == bmpdec_pkg::MODE_24BPP) ? 2'd2 : 2'd3;
                     if (ph_in == 2'd0) stg_in[23:16] = b;
                     else if (ph_in == 2'd1) stg_in[15:8] = b;
                     else if (ph_in == 2'd2) stg_in[7:0] = b;
                     if (ph_in == endp) begin
                        n = (left > 13'd0) ? 13'd1 : 13'd0;
                        job.rgb = {stg_in[7:0], stg_in[15:8], stg_in[23:16]};
                        if (mode_in == bmpdec_pkg::MODE_32BPP) job.alpha = b;
                        ph_in = '0; stg_in = '0;
                     end else begin
                        ph_in = ph_in + 2'd1;
                     end
                  end
               endcase
               job.count = n[3:0];
               job_valid = (n != 13'd0);
               col_in = col_in + n;
               rbc_in = rbc_in + 15'd1;
               if (rbc_in >= stride_in) begin
                  rbc_in = '0; col_in = '0; ph_in = '0; stg_in = '0;
                  if (row_in == 13'd0) halt_in = 1'b1;
                  else row_in = row_in - 13'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halt_ff <= 1'b1; off_ff <= '0; sh_ff <= '0; sig_ff <= '0; w_ff <= '0;
         h_ff <= '0; mode_ff <= bmpdec_pkg::MODE_NONE; col_ff <= '0; row_ff <= '0;
         rbc_ff <= '0; stride_ff <= '0; ph_ff <= '0; stg_ff <= '0;
      end else begin
         halt_ff <= halt_in; off_ff <= off_in; sh_ff <= sh_in; sig_ff <= sig_in;
         w_ff <= w_in; h_ff <= h_in; mode_ff <= mode_in; col_ff <= col_in;
         row_ff <= row_in; rbc_ff <= rbc_in; stride_ff <= stride_in;
         ph_ff <= ph_in; stg_ff <= stg_in;
      end
   end

   bmpdec_emit #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_emit (
      .clock(clock), .reset(reset),
      .pal_we(pal_we), .pal_addr(pal_addr),
      .pal_data({req_data.data_byte, stg_ff[15:0]}),
      .job_valid(job_valid && acc), .job_ready(job_ready), .job(job),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming bmp pixel decoder: builds small bmp
// files byte by byte, predicts every pixel and status item, checks in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// holds the predicted decoder state and the queue of pending result items
class pixel_scoreboard;
   logic [10:0]          offset;
   logic [31:0]          shifter;
   logic [15:0]          sig;
   logic [31:0]          width;
   logic [31:0]          height;
   bmpdec_pkg::mode_type mode;
   logic [23:0]          palette [256];
   logic [31:0]          col;
   logic [31:0]          row;
   logic [31:0]          row_bytes;
   logic [31:0]          stride;
   logic [1:0]           phase;
   logic [23:0]          stage;
   bit                   idle_file;
   bmpdec_pkg::rsp_type  pending[$];
   int                   errors;

   function new();
      offset = '0; shifter = '0; sig = '0; width = '0; height = '0;
      mode = bmpdec_pkg::MODE_NONE; col = '0; row = '0; row_bytes = '0;
      stride = '0; phase = '0; stage = '0; idle_file = 1'b1; errors = 0;
      foreach (palette[i]) palette[i] = '0;
   endfunction

   function void add(bmpdec_pkg::kind_type k, logic [23:0] rgb, logic [7:0] a);
      bmpdec_pkg::rsp_type r;
      bit pix;
      pix = (k == bmpdec_pkg::KIND_PIXEL);
      r.kind  = k;
      r.pix_x = pix ? col[11:0] : 12'd0;
      r.pix_y = pix ? row[11:0] : 12'd0;
      r.red   = pix ? rgb[23:16] : 8'd0;
      r.green = pix ? rgb[15:8] : 8'd0;
      r.blue  = pix ? rgb[7:0] : 8'd0;
      r.alpha = pix ? a : 8'd0;
      r.last  = 1'b0;
      pending.push_back(r);
   endfunction

   function int entries();
      case (mode)
         bmpdec_pkg::MODE_1BPP: return 2;
         bmpdec_pkg::MODE_4BPP: return 16;
         bmpdec_pkg::MODE_8BPP: return 256;
         default:               return 0;
      endcase
   endfunction

   function int bits();
      case (mode)
         bmpdec_pkg::MODE_1BPP:  return 1;
         bmpdec_pkg::MODE_4BPP:  return 4;
         bmpdec_pkg::MODE_8BPP:  return 8;
         bmpdec_pkg::MODE_24BPP: return 24;
         bmpdec_pkg::MODE_32BPP: return 32;
         default:                return 0;
      endcase
   endfunction

   function void indexed(int idx);
      if (col < width) begin
         add(bmpdec_pkg::KIND_PIXEL, palette[idx], 8'hFF);
         col++;
      end
   endfunction

   function void header(logic [7:0] b);
      int off;
      logic [15:0] bc;
      off = int'(offset);
      shifter = {b, shifter[31:8]};
      offset++;
      if (off == 1) sig = shifter[31:16];
      else if (off == 21) width = shifter;
      else if (off == 25) height = shifter;
      else if (off == 29) begin
         bc = shifter[31:16];
         mode = bc == 1 ? bmpdec_pkg::MODE_1BPP : bc == 4 ? bmpdec_pkg::MODE_4BPP :
                bc == 8 ? bmpdec_pkg::MODE_8BPP : bc == 24 ? bmpdec_pkg::MODE_24BPP :
                bc == 32 ? bmpdec_pkg::MODE_32BPP : bmpdec_pkg::MODE_NONE;
      end else if (off == bmpdec_pkg::HeaderBytes - 1) begin
         if (sig != bmpdec_pkg::BmpMagic) begin
            add(bmpdec_pkg::KIND_BAD_SIG, '0, '0); idle_file = 1'b1;
         end else if (mode == bmpdec_pkg::MODE_NONE) begin
            add(bmpdec_pkg::KIND_BAD_BPP, '0, '0); idle_file = 1'b1;
         end else if (width > bmpdec_pkg::MaxDim || height > bmpdec_pkg::MaxDim) begin
            add(bmpdec_pkg::KIND_TOO_BIG, '0, '0); idle_file = 1'b1;
         end else if (width == 0 || height == 0) idle_file = 1'b1;
         else begin
            stride = (((width * bits() + 7) >> 3) + 3) & ~32'd3;
            row = height - 1; col = '0; row_bytes = '0; phase = '0; stage = '0;
         end
      end
   endfunction

   function void pixel(logic [7:0] b);
      int endp;
      case (mode)
         bmpdec_pkg::MODE_1BPP: for (int k = 0; k < 8; k++) indexed(int'(b[7-k]));
         bmpdec_pkg::MODE_4BPP: begin indexed(int'(b[7:4])); indexed(int'(b[3:0])); end
         bmpdec_pkg::MODE_8BPP: indexed(int'(b));
         bmpdec_pkg::MODE_24BPP, bmpdec_pkg::MODE_32BPP: begin
            endp = (mode == bmpdec_pkg::MODE_24BPP) ? 2 : 3;
            if (phase < 3) stage |= 24'(b) << (8 * (2 - phase));
            if (phase == endp) begin
               // stage holds b,g,r from high to low
               if (col < width) begin
                  add(bmpdec_pkg::KIND_PIXEL, {stage[7:0], stage[15:8], stage[23:16]},
                      mode == bmpdec_pkg::MODE_32BPP ? b : 8'hFF);
                  col++;
               end
               phase = '0; stage = '0;
            end else phase++;
         end
         default: ;
      endcase
      row_bytes++;
      if (row_bytes >= stride) begin
         row_bytes = '0; col = '0; phase = '0; stage = '0;
         if (row == 0) idle_file = 1'b1;
         else row--;
      end
   endfunction

   // note one accepted input item
   function void note_input(bmpdec_pkg::req_type q);
      int before_n;
      int p;
      before_n = pending.size();
      if (q.first) begin
         offset = '0; shifter = '0; sig = '0; width = '0; height = '0;
         mode = bmpdec_pkg::MODE_NONE; col = '0; row = '0; row_bytes = '0;
         stride = '0; phase = '0; stage = '0;
         idle_file = 1'b0;
      end
      if (idle_file) return;
      if (offset < bmpdec_pkg::HeaderBytes) header(q.data_byte);
      else if (offset < bmpdec_pkg::HeaderBytes + 4 * entries()) begin
         p = int'(offset) - int'(bmpdec_pkg::HeaderBytes);
         offset++;
         case (p % 4)
            0: stage = {16'd0, q.data_byte};
            1: stage[15:8] = q.data_byte;
            2: begin
               stage[23:16] = q.data_byte;
               if (p / 4 < 256) palette[p/4] = stage;
               stage = '0;
            end
            default: ;
         endcase
      end else pixel(q.data_byte);
      if (pending.size() > before_n) pending[$].last = 1'b1;
   endfunction

   // check one accepted result item
   function void check_result(bmpdec_pkg::rsp_type r);
      bmpdec_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected item kind=%0d", r.kind);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (r.kind !== e.kind) begin $error("kind exp %0d got %0d", e.kind, r.kind); errors++; end
      if (r.pix_x !== e.pix_x) begin $error("pix_x exp %0d got %0d", e.pix_x, r.pix_x); errors++; end
      if (r.pix_y !== e.pix_y) begin $error("pix_y exp %0d got %0d", e.pix_y, r.pix_y); errors++; end
      if (r.red !== e.red) begin $error("red exp %0h got %0h", e.red, r.red); errors++; end
      if (r.green !== e.green) begin
         $error("green exp %0h got %0h", e.green, r.green); errors++;
      end
      if (r.blue !== e.blue) begin $error("blue exp %0h got %0h", e.blue, r.blue); errors++; end
      if (r.alpha !== e.alpha) begin
         $error("alpha exp %0h got %0h", e.alpha, r.alpha); errors++;
      end
      if (r.last !== e.last) begin $error("last exp %0d got %0d", e.last, r.last); errors++; end
   endfunction
endclass

module tb_top;
   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_stall;
   bmpdec_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   bmpdec_pkg::rsp_type rsp_data;

   int send_idle_pct = 21;
   int recv_idle_pct = 76;

   pixel_scoreboard board = new();

   // file image under construction
   byte unsigned file_bytes[$];

   bmp_stream_pixel_decoder DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // receiver: random stall, checks each accepted result item
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // sender side: random gap then hold the item until accepted
   task automatic send_byte(input logic [7:0] b, input logic f);
      bmpdec_pkg::req_type q;
      q.data_byte = b;
      q.first = f;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_input(q);
   endtask

   task automatic put16(input logic [15:0] v);
      file_bytes.push_back(v[7:0]); file_bytes.push_back(v[15:8]);
   endtask

   task automatic put32(input logic [31:0] v);
      for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
   endtask

   // builds a header plus palette plus pixel data; junk fills unused fields
   task automatic build_file(input logic [15:0] magic, input logic [31:0] w,
                             input logic [31:0] h, input int bpp, input bit junk);
      int pal;
      int stride;
      file_bytes.delete();
      put16(magic);
      for (int i = 2; i < 18; i++)
         file_bytes.push_back(junk ? 8'($urandom_range(255)) : 8'd0);
      put32(w); put32(h);
      put16(16'd1); put16(16'(bpp));
      for (int i = 30; i < 54; i++)
         file_bytes.push_back(junk ? 8'($urandom_range(255)) : 8'd0);
      pal = bpp == 1 ? 2 : bpp == 4 ? 16 : bpp == 8 ? 256 : 0;
      for (int i = 0; i < 4 * pal; i++) file_bytes.push_back(8'($urandom_range(255)));
      if (w <= bmpdec_pkg::MaxDim && h <= bmpdec_pkg::MaxDim &&
          magic == bmpdec_pkg::BmpMagic) begin
         stride = (((int'(w) * bpp + 7) >> 3) + 3) & ~3;
         for (int i = 0; i < stride * int'(h); i++)
            file_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic send_file(input int extra);
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
      // trailing bytes past the last row are ignored
      for (int i = 0; i < extra; i++) send_byte(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;

      // stray bytes before any first are ignored
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // header error cases and a few extremes
      build_file(16'h4D43, 4, 1, 24, 1'b1); send_file(1);
      build_file(bmpdec_pkg::BmpMagic, 1, 0, 16, 1'b1); send_file(0);
      build_file(bmpdec_pkg::BmpMagic, 4097, 1, 24, 1'b1); send_file(0);
      build_file(bmpdec_pkg::BmpMagic, 1, 32'hFFFF_FFFF, 24, 1'b0); send_file(0);
      build_file(bmpdec_pkg::BmpMagic, 0, 3, 24, 1'b0); send_file(0);
      drain();  // sender holds off until every expected item is back
      // full bytes of eight pixels at 1 bpp
      build_file(bmpdec_pkg::BmpMagic, 9, 2, 1, 1'b1); send_file(2);
      // restart mid-file
      build_file(bmpdec_pkg::BmpMagic, 6, 3, 4, 1'b0);
      for (int i = 0; i < 20; i++) send_byte(file_bytes[i], i == 0);

      send_idle_pct = 76;
      recv_idle_pct = 21;
      build_file(bmpdec_pkg::BmpMagic, 2, 2, 32, 1'b1); send_file(1);
      build_file(bmpdec_pkg::BmpMagic, 3, 1, 4, 1'b1); send_file(0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      build_file(bmpdec_pkg::BmpMagic, 2, 1, 24, 1'b1); send_file(1);

      drain();
      if (board.errors == 0 && board.pending.size() == 0) $display("tb_top passed");
      else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // generous run limit
   initial begin
      #4000000;
      $display("tb_top failed");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/bmpdec_pkg.sv
rtl/core/bmpdec_emit.sv
rtl/core/bmp_stream_pixel_decoder.sv
verif/tb_top.sv
